// File: rtl/core/qoi_pkg.sv
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types, op codes and the colour index hash for the chunk decoder.
// ----------------------------------------------------------------------------
package qoi_pkg;

  // One RGBA pixel, red in the top byte
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  // Op still gathering payload bytes
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_RGB  = 2'd1,
    OP_RGBA = 2'd2,
    OP_LUMA = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_INDEX = 2'd1,
    ST_RUN   = 2'd2
  } state_t;

  // Two-bit op tags in the top of a chunk byte
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  // Full-byte op codes
  localparam logic [7:0] BYTE_RGB  = 8'hFE;
  localparam logic [7:0] BYTE_RGBA = 8'hFF;

  // Argument field of a tagged byte
  localparam int unsigned ARG_W = 6;

  // Delta biases (LUMA red/blue fold the green and the nibble bias together)
  localparam logic [7:0] DIFF_BIAS   = 8'd2;
  localparam logic [7:0] LUMA_G_BIAS = 8'd32;
  localparam logic [7:0] LUMA_RB_BIAS = 8'd40;

  // Previous pixel at the start of an image
  localparam pixel_t PIXEL_INIT = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

  // Width of the raw hash sum: 26 * 255 fits in 13 bits
  localparam int unsigned HASH_W = 13;

  // Raw hash sum 3r + 5g + 7b + 11a; callers keep the low index bits
  function automatic logic [HASH_W-1:0] px_hash(input pixel_t p);
    logic [HASH_W-1:0] sum;
    sum = HASH_W'(p.r) * HASH_W'(3) + HASH_W'(p.g) * HASH_W'(5)
        + HASH_W'(p.b) * HASH_W'(7) + HASH_W'(p.a) * HASH_W'(11);
    return sum;
  endfunction

endpackage

// File: rtl/core/qoi_ram.sv
// ----------------------------------------------------------------------------
// qoi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qoi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/qoi_chunk_decoder_core.sv
// ----------------------------------------------------------------------------
// qoi_chunk_decoder_core
// Decodes a QOI chunk stream, one byte per transfer, into RGBA pixels.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | code_byte, image_start
//  out_    | output    | out_valid/out_stall| red, green, blue, alpha,
//          |           |                    | last_of_run
//
// Sequencing: RGB, RGBA, DIFF and LUMA bytes are handled in ST_IDLE. An INDEX
// byte waits in ST_INDEX for the registered read of the colour index RAM.
// A RUN byte with argument l emits l+1 pixels through the output register.
// Reset: synchronous; valid flops of the colour index clear at once, so no
// clearing pass is needed. Stalls: out_stall holds the output register; the
// input stalls while a run or an index read is in progress or the output is
// full and held.
module qoi_chunk_decoder_core #(
  parameter int unsigned INDEX_ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  // Chunk byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_code_byte,
  input  logic       in_image_start,
  // Pixel output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       out_last_of_run
);

  import qoi_pkg::*;

  localparam int unsigned IDX_W = $clog2(INDEX_ENTRIES);

  // Control state
  state_t            state_r, state_nxt;
  op_t               pend_op_r, pend_op_nxt;
  logic [1:0]        pend_cnt_r, pend_cnt_nxt;
  logic [ARG_W-1:0]  run_left_r, run_left_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [INDEX_ENTRIES-1:0] valid_r, valid_nxt;

  // Payload state
  pixel_t            prev_r, prev_nxt;
  logic [23:0]       gath_r, gath_nxt;
  logic [ARG_W-1:0]  luma_dg_r, luma_dg_nxt;
  logic [IDX_W-1:0]  idx_addr_r, idx_addr_nxt;
  pixel_t            out_px_r, out_px_nxt;
  logic              out_last_r, out_last_nxt;

  // Handshake and decode
  logic              acc;
  logic              drain_ok;
  pixel_t            prev_eff;
  op_t               pend_eff;
  logic [1:0]        tag;
  logic [ARG_W-1:0]  arg;
  logic              full_op;

  // Index RAM
  logic              ram_we;
  pixel_t            ram_wdata;
  logic [IDX_W-1:0]  ram_waddr;
  pixel_t            ram_rdata;
  pixel_t            idx_px;
  logic [HASH_W-1:0] wr_hash;

  assign drain_ok = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && drain_ok);
  assign acc      = in_valid && !in_stall;

  assign prev_eff = in_image_start ? PIXEL_INIT : prev_r;
  assign pend_eff = in_image_start ? OP_NONE : pend_op_r;
  assign tag      = in_code_byte[7:6];
  assign arg      = in_code_byte[ARG_W-1:0];
  assign full_op  = (in_code_byte == BYTE_RGB) || (in_code_byte == BYTE_RGBA);

  // Entry that was never written since the image start reads as zero
  assign idx_px = valid_r[idx_addr_r] ? ram_rdata : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (pend_eff == OP_NONE) && !full_op) begin
          if (tag == TAG_INDEX) begin
            state_nxt = ST_INDEX;
          end else if ((tag == TAG_RUN) && (arg != '0)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_INDEX: state_nxt = ST_IDLE;
      ST_RUN: begin
        if (drain_ok && (run_left_r == ARG_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath: gather bytes, build pixels, load the output register
  always_comb begin
    logic   emit;
    pixel_t emit_px;
    logic   emit_last;
    logic   run_wr;

    emit      = 1'b0;
    emit_px   = prev_eff;
    emit_last = 1'b1;
    run_wr    = 1'b0;

    pend_op_nxt  = pend_op_r;
    pend_cnt_nxt = pend_cnt_r;
    gath_nxt     = gath_r;
    luma_dg_nxt  = luma_dg_r;
    idx_addr_nxt = idx_addr_r;
    run_left_nxt = run_left_r;
    prev_nxt     = prev_r;

    if (acc) begin
      if (in_image_start) begin
        prev_nxt     = PIXEL_INIT;
        pend_op_nxt  = OP_NONE;
        pend_cnt_nxt = '0;
      end
      unique case (pend_eff)
        OP_RGB, OP_RGBA: begin
          // Collect one channel; the final byte goes straight to the pixel
          unique case (pend_cnt_r & {2{pend_op_r == pend_eff}})
            2'd0:    gath_nxt[23:16] = in_code_byte;
            2'd1:    gath_nxt[15:8]  = in_code_byte;
            2'd2:    gath_nxt[7:0]   = in_code_byte;
            default: gath_nxt        = gath_r;
          endcase
          if ((pend_eff == OP_RGB) && (pend_cnt_r == 2'd2)) begin
            emit         = 1'b1;
            emit_px      = '{r: gath_r[23:16], g: gath_r[15:8], b: in_code_byte,
                             a: prev_eff.a};
            pend_op_nxt  = OP_NONE;
            pend_cnt_nxt = '0;
          end else if ((pend_eff == OP_RGBA) && (pend_cnt_r == 2'd3)) begin
            emit         = 1'b1;
            emit_px      = '{r: gath_r[23:16], g: gath_r[15:8], b: gath_r[7:0],
                             a: in_code_byte};
            pend_op_nxt  = OP_NONE;
            pend_cnt_nxt = '0;
          end else begin
            pend_cnt_nxt = pend_cnt_r + 2'd1;
          end
        end
        OP_LUMA: begin
          // Second LUMA byte: red and blue offsets relative to green
          emit         = 1'b1;
          emit_px.r    = prev_eff.r + 8'(luma_dg_r) + 8'(in_code_byte[7:4]) - LUMA_RB_BIAS;
          emit_px.g    = prev_eff.g + 8'(luma_dg_r) - LUMA_G_BIAS;
          emit_px.b    = prev_eff.b + 8'(luma_dg_r) + 8'(in_code_byte[3:0]) - LUMA_RB_BIAS;
          emit_px.a    = prev_eff.a;
          pend_op_nxt  = OP_NONE;
          pend_cnt_nxt = '0;
        end
        OP_NONE: begin
          if (full_op) begin
            pend_op_nxt  = (in_code_byte == BYTE_RGB) ? OP_RGB : OP_RGBA;
            pend_cnt_nxt = '0;
          end else begin
            unique case (tag)
              TAG_INDEX: idx_addr_nxt = in_code_byte[IDX_W-1:0];
              TAG_DIFF: begin
                emit      = 1'b1;
                emit_px.r = prev_eff.r + 8'(in_code_byte[5:4]) - DIFF_BIAS;
                emit_px.g = prev_eff.g + 8'(in_code_byte[3:2]) - DIFF_BIAS;
                emit_px.b = prev_eff.b + 8'(in_code_byte[1:0]) - DIFF_BIAS;
                emit_px.a = prev_eff.a;
              end
              TAG_LUMA: begin
                luma_dg_nxt  = arg;
                pend_op_nxt  = OP_LUMA;
                pend_cnt_nxt = '0;
              end
              TAG_RUN: begin
                // First run pixel now, the rest from the run counter
                run_wr       = 1'b1;
                emit_px      = prev_eff;
                emit_last    = (arg == '0);
                run_left_nxt = arg;
              end
              default: emit = 1'b0;
            endcase
          end
        end
        default: emit = 1'b0;
      endcase
    end else if (state_r == ST_INDEX) begin
      emit    = 1'b1;
      emit_px = idx_px;
    end else if ((state_r == ST_RUN) && drain_ok) begin
      emit_px      = prev_r;
      emit_last    = (run_left_r == ARG_W'(1));
      run_left_nxt = run_left_r - ARG_W'(1);
    end

    if (emit) begin
      prev_nxt = emit_px;
    end

    // Colour index write: every decoded pixel, and the run pixel once
    wr_hash   = px_hash(emit_px);
    ram_we    = emit || run_wr;
    ram_wdata = emit_px;
    ram_waddr = wr_hash[IDX_W-1:0];

    // Output register
    if (emit || run_wr || ((state_r == ST_RUN) && drain_ok)) begin
      out_valid_nxt = 1'b1;
      out_px_nxt    = emit_px;
      out_last_nxt  = emit_last;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
      out_px_nxt    = out_px_r;
      out_last_nxt  = out_last_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_op_r   <= OP_NONE;
      pend_cnt_r  <= '0;
      run_left_r  <= '0;
      out_valid_r <= 1'b0;
      prev_r      <= PIXEL_INIT;
    end else begin
      state_r     <= state_nxt;
      pend_op_r   <= pend_op_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      run_left_r  <= run_left_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
    end
  end

  // Index valid bits: drop all at image start, set on each write
  always_comb begin
    valid_nxt = valid_r;
    if (acc && in_image_start) begin
      valid_nxt = '0;
    end
    if (ram_we) begin
      valid_nxt[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    gath_r     <= gath_nxt;
    luma_dg_r  <= luma_dg_nxt;
    idx_addr_r <= idx_addr_nxt;
    out_px_r   <= out_px_nxt;
    out_last_r <= out_last_nxt;
  end

  // Colour index; a write always lands before any read
  // of the next byte, so no forwarding path is needed
  qoi_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (INDEX_ENTRIES)
  ) u_index_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (in_code_byte[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_red         = out_px_r.r;
  assign out_green       = out_px_r.g;
  assign out_blue        = out_px_r.b;
  assign out_alpha       = out_px_r.a;
  assign out_last_of_run = out_last_r;

  // Checks
  a_run_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (run_left_r != '0))
    else $error("run state with no pixels left");

  a_index_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INDEX) |-> !out_valid_r)
    else $error("output register busy when index data returns");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(ram_waddr)])
    else $error("index write did not mark its entry valid");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_image_start && !ram_we) |=> (valid_r == '0))
    else $error("image start left index entries valid");

endmodule
